@@ sv/service_queue_time_drain_core_assert.svh @@
// assertion macros for the service queue time drain core
`ifndef SERVICE_QUEUE_TIME_DRAIN_CORE_ASSERT_SVH
`define SERVICE_QUEUE_TIME_DRAIN_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SQTD_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sqtd check failed");
`define SQTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sqtd check failed");
`else
`define SQTD_ASSERT(lbl, expr)
`define SQTD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/sqtd_pkg.sv @@
// shared constants and types for the service queue time drain core
package sqtd_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int TM_W        = 16;
  localparam int ELAPSED_W   = 20;
  localparam int CMD_W       = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DRAIN  = 2'd1,
    ST_REPORT = 2'd2
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

@@ sv/sqtd_cell.sv @@
// one queue slot: holds an entry and takes its neighbor's entry on a shift
module sqtd_cell (
  input  logic                clk,
  input  sqtd_pkg::cell_ctl_t ctl,
  input  logic [15:0]         new_id,
  input  logic [15:0]         new_time,
  input  logic [15:0]         nbr_id,
  input  logic [15:0]         nbr_time,
  output logic [15:0]         ent_id,
  output logic [15:0]         ent_time
);
  import sqtd_pkg::*;

  logic [ID_W-1:0] id_r;
  logic [TM_W-1:0] tm_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      id_r <= new_id;
      tm_r <= new_time;
    end else if (ctl.shift) begin
      id_r <= nbr_id;
      tm_r <= nbr_time;
    end
  end

  assign ent_id   = id_r;
  assign ent_time = tm_r;

endmodule

@@ sv/service_queue_time_drain_core.sv @@
// top level of the service queue time drain core
// usage:
//   in_* is a stream of commands; in_tuser carries the command (enqueue, dequeue,
//   drain, no-op), in_tdata the entry id, service time and elapsed time.
//   out_* returns one result transfer per command with the head entry, empty
//   flag, entry count, found id, found and overflow flags.
//   entries sit in a row of slot cells; slot 0 is the head, a dequeue shifts
//   every slot one step toward the head, an enqueue writes the slot at the count.
//   steps: enqueue, dequeue and no-op go from the input transfer through the
//   report state to out_tvalid; a drain first passes the drain state, which
//   removes one slot per cycle at the head cell, then the report state.
//   one command is worked at a time; the next is taken as soon as the block is
//   back to idle, even while the previous result still waits in the output
//   register.
//   reset empties the queue (count and state cleared); slot contents are not
//   cleared and are never shown while the queue is empty.
//   a stalled receiver holds the result in the output register; a finished
//   command then waits before reporting and no further command is taken.
module service_queue_time_drain_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_id [15:0], service_time [31:16], elapsed_time [51:32], zero pad
  input  logic [55:0] in_tdata,
  // command [1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // head_id [15:0], head_time [31:16], queue_empty [32], entry_count [37:33],
  // found_id [53:38], found [54], overflow [55]
  output logic [55:0] out_tdata
);
  import sqtd_pkg::*;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ELAPSED_W-1:0]  remain_r, remain_nxt;
  logic                  found_r, found_nxt;
  logic [ID_W-1:0]       found_id_r, found_id_nxt;
  logic                  overflow_r, overflow_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic [ID_W-1:0]       cell_id   [QUEUE_DEPTH];
  logic [TM_W-1:0]       cell_time [QUEUE_DEPTH];
  logic                  load_en;
  logic                  shift_en;
  logic                  in_xfer;
  logic                  out_free;
  cmd_t                  cmd;
  logic [ID_W-1:0]       in_id;
  logic [TM_W-1:0]       in_time;
  logic [ELAPSED_W-1:0]  in_elapsed;
  logic [ELAPSED_W-1:0]  head_tm_ext;
  logic                  q_empty;

  assign cmd         = cmd_t'(in_tuser);
  assign in_id       = in_tdata[15:0];
  assign in_time     = in_tdata[31:16];
  assign in_elapsed  = in_tdata[51:32];
  assign in_tready   = (state_r == ST_IDLE);
  assign in_xfer     = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign head_tm_ext = ELAPSED_W'(cell_time[0]);
  assign q_empty     = (count_r == '0);

  // slot row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t        ctl;
    logic [ID_W-1:0]  nbr_id;
    logic [TM_W-1:0]  nbr_time;

    assign ctl = '{load: load_en && (count_r == CNT_W'(i)), shift: shift_en};

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nbr_id   = cell_id[i];
      assign nbr_time = cell_time[i];
    end else begin : g_mid
      assign nbr_id   = cell_id[i+1];
      assign nbr_time = cell_time[i+1];
    end

    sqtd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_id   (in_id),
      .new_time (in_time),
      .nbr_id   (nbr_id),
      .nbr_time (nbr_time),
      .ent_id   (cell_id[i]),
      .ent_time (cell_time[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (cmd == CMD_DRAIN) ? ST_DRAIN : ST_REPORT;
        end
      end
      ST_DRAIN: begin
        if (q_empty || (head_tm_ext >= remain_r)) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    load_en       = 1'b0;
    shift_en      = 1'b0;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    found_nxt     = found_r;
    found_id_nxt  = found_id_r;
    overflow_nxt  = overflow_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          found_nxt    = 1'b0;
          found_id_nxt = '0;
          overflow_nxt = 1'b0;
          remain_nxt   = in_elapsed;
          case (cmd)
            CMD_ENQ: begin
              if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
                overflow_nxt = 1'b1;
              end else begin
                load_en   = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_DEQ: begin
              if (!q_empty) begin
                shift_en  = 1'b1;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (!q_empty) begin
          if (head_tm_ext >= remain_r) begin
            found_nxt    = 1'b1;
            found_id_nxt = cell_id[0];
          end else begin
            remain_nxt = remain_r - head_tm_ext;
            shift_en   = 1'b1;
            count_nxt  = count_r - CNT_W'(1);
          end
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = {overflow_r, found_r, found_id_r,
                           COUNT_OUT_W'(count_r), q_empty,
                           q_empty ? {TM_W{1'b0}} : cell_time[0],
                           q_empty ? {ID_W{1'b0}} : cell_id[0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    remain_r    <= remain_nxt;
    found_r     <= found_nxt;
    found_id_r  <= found_id_nxt;
    overflow_r  <= overflow_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

`include "service_queue_time_drain_core_assert.svh"

  `SQTD_ASSERT(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH))
  `SQTD_ASSERT_NEXT(a_drain_step, state_r == ST_DRAIN,
                    (count_r == $past(count_r)) || (count_r == $past(count_r) - CNT_W'(1)))
  `SQTD_ASSERT(a_flags_excl, (state_r != ST_REPORT) || !(found_r && overflow_r))
  `SQTD_ASSERT_NEXT(a_report, (state_r == ST_REPORT) && out_free,
                    out_valid_r && (state_r == ST_IDLE))

endmodule

@@ tb/testbench.sv @@
// testbench for the service queue time drain core: directed, full-queue, random and pressure tests
`timescale 1ns / 1ps

module testbench;
  import sqtd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int MAX_REPORTS    = 10;
  localparam logic [19:0] BUDGET_MAX = 20'hFFFFF;

  // packed from msb down so that head_id sits in the lowest bits
  typedef struct packed {
    logic        overflow;
    logic        found;
    logic [15:0] found_id;
    logic [4:0]  entry_count;
    logic        queue_empty;
    logic [15:0] head_time;
    logic [15:0] head_id;
  } queue_status_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  // queue model state
  logic [15:0] slot_id [QUEUE_DEPTH];
  logic [15:0] slot_time [QUEUE_DEPTH];
  int          slot_head = 0;
  int          slot_tail = 0;
  int          slot_fill = 0;

  queue_status_t pending_status [$];

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int mismatch_count = 0;
  int result_index   = 0;
  int quiet_cycles   = 0;

  service_queue_time_drain_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic queue_status_t predict_status(input cmd_t op, input logic [15:0] id,
                                                   input logic [15:0] svc,
                                                   input logic [19:0] budget);
    queue_status_t r;
    int unsigned remain;
    r = '0;
    case (op)
      CMD_ENQ: begin
        if (slot_fill >= QUEUE_DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          slot_id[slot_tail] = id;
          slot_time[slot_tail] = svc;
          slot_tail = (slot_tail + 1) % QUEUE_DEPTH;
          slot_fill++;
        end
      end
      CMD_DEQ: begin
        if (slot_fill != 0) begin
          slot_head = (slot_head + 1) % QUEUE_DEPTH;
          slot_fill--;
        end
      end
      CMD_DRAIN: begin
        remain = budget;
        while (slot_fill != 0) begin
          if (slot_time[slot_head] >= remain) begin
            r.found = 1'b1;
            r.found_id = slot_id[slot_head];
            break;
          end
          remain -= slot_time[slot_head];
          slot_head = (slot_head + 1) % QUEUE_DEPTH;
          slot_fill--;
        end
      end
      default: ;
    endcase
    if (slot_fill != 0) begin
      r.head_id = slot_id[slot_head];
      r.head_time = slot_time[slot_head];
    end
    r.queue_empty = (slot_fill == 0);
    r.entry_count = slot_fill[4:0];
    return r;
  endfunction

  // total service time of the first n queued entries
  function automatic int unsigned queued_time_sum(input int n);
    int unsigned total;
    total = 0;
    for (int i = 0; i < n && i < slot_fill; i++) begin
      total += slot_time[(slot_head + i) % QUEUE_DEPTH];
    end
    return total;
  endfunction

  function automatic logic [15:0] random_service_time();
    case ($urandom_range(4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 16));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic issue_command(input cmd_t op, input logic [15:0] id, input logic [15:0] svc,
                               input logic [19:0] budget);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, budget, svc, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_status.push_back(predict_status(op, id, svc, budget));
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic issue_drain_near_boundary();
    int          k;
    int unsigned total;
    logic [19:0] budget;
    k = $urandom_range(0, slot_fill);
    total = queued_time_sum(k);
    case ($urandom_range(5))
      0: budget = 20'(total);
      1: budget = 20'(total + 1);
      2: budget = (total > 0) ? 20'(total - 1) : 20'd0;
      3: budget = 20'd0;
      4: budget = BUDGET_MAX;
      default: budget = 20'($urandom_range(0, BUDGET_MAX));
    endcase
    issue_command(CMD_DRAIN, 16'($urandom), 16'($urandom), budget);
  endtask

  task automatic test_directed();
    issue_command(CMD_DEQ, 16'h0000, 16'h0000, 20'h00000);
    issue_command(CMD_DRAIN, 16'hFFFF, 16'hFFFF, BUDGET_MAX);
    issue_command(CMD_DRAIN, 16'h0000, 16'h0000, 20'h00000);
    issue_command(CMD_NOP, 16'hFFFF, 16'hFFFF, BUDGET_MAX);
    issue_command(CMD_ENQ, 16'h0000, 16'h0000, 20'h00000);
    issue_command(CMD_ENQ, 16'hFFFF, 16'hFFFF, BUDGET_MAX);
    issue_command(CMD_ENQ, 16'h1234, 16'd10, 20'h00000);
    // zero budget finds the head at once
    issue_command(CMD_DRAIN, 16'h0000, 16'h0000, 20'h00000);
    // zero service time head is removed
    issue_command(CMD_DRAIN, 16'h0000, 16'h0000, 20'h00001);
    issue_command(CMD_ENQ, 16'h5A5A, 16'h0000, 20'h00000);
    issue_command(CMD_ENQ, 16'hA5A5, 16'd7, 20'h00000);
    // remainder equals the second entry's service time, so that entry is found
    issue_command(CMD_DRAIN, 16'h0000, 16'h0000, 20'(queued_time_sum(2)));
    issue_command(CMD_DEQ, 16'hFFFF, 16'hFFFF, BUDGET_MAX);
    issue_command(CMD_DRAIN, 16'h0000, 16'h0000, 20'h00003);
    issue_command(CMD_DRAIN, 16'h0000, 16'h0000, BUDGET_MAX);
    issue_command(CMD_NOP, 16'h0000, 16'h0000, 20'h00000);
    issue_command(CMD_DEQ, 16'h0000, 16'h0000, 20'h00000);
    issue_command(CMD_ENQ, 16'h8001, 16'h8000, 20'h80000);
    issue_command(CMD_NOP, 16'h7FFE, 16'h7FFF, 20'h7FFFF);
    issue_command(CMD_DRAIN, 16'h0000, 16'h0000, 20'(queued_time_sum(1) + 1));
  endtask

  task automatic test_queue_full();
    repeat (QUEUE_DEPTH + 2)
      issue_command(CMD_ENQ, 16'($urandom), random_service_time(), 20'h00000);
    issue_command(CMD_DEQ, 16'h0000, 16'h0000, 20'h00000);
    issue_command(CMD_ENQ, 16'hBEEF, 16'd1, 20'h00000);
    issue_command(CMD_ENQ, 16'hDEAD, 16'd2, 20'h00000);
    issue_command(CMD_DRAIN, 16'h0000, 16'h0000, BUDGET_MAX);
  endtask

  task automatic test_random_traffic(input int n_items, input int gap_pct, input int stall_pct);
    int sent;
    int pick;
    int burst;
    sent = 0;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        burst = $urandom_range(1, 6);
        repeat (burst)
          issue_command(CMD_ENQ, 16'($urandom), random_service_time(), 20'($urandom));
      end else if (pick < 42) begin
        burst = QUEUE_DEPTH - slot_fill + $urandom_range(1, 2);
        repeat (burst)
          issue_command(CMD_ENQ, 16'($urandom), random_service_time(), 20'($urandom));
      end else if (pick < 75) begin
        burst = 1;
        issue_drain_near_boundary();
      end else if (pick < 90) begin
        burst = $urandom_range(1, 2);
        repeat (burst)
          issue_command(CMD_DEQ, 16'($urandom), 16'($urandom), 20'($urandom));
      end else begin
        burst = 1;
        issue_command(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                      20'($urandom));
      end
      sent += burst;
    end
  endtask

  task automatic test_backpressure();
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_requests++;
    repeat (12) issue_command(CMD_ENQ, 16'($urandom), random_service_time(), 20'($urandom));
    repeat (14) issue_drain_near_boundary();
    repeat (14)
      issue_command(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                    20'($urandom));
  endtask

  task automatic test_pause_until_drained();
    send_gap_pct = 15;
    recv_stall_pct = 15;
    repeat (8) issue_command(CMD_ENQ, 16'($urandom), random_service_time(), 20'($urandom));
    wait_results_done();
    repeat (2) issue_drain_near_boundary();
    wait_results_done();
    repeat (8)
      issue_command(cmd_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                    20'($urandom));
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    queue_status_t got;
    queue_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pending_status.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("unexpected result transfer %0d: %h", result_index, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        if (got.head_id !== want.head_id || got.head_time !== want.head_time ||
            got.queue_empty !== want.queue_empty || got.entry_count !== want.entry_count ||
            got.found_id !== want.found_id || got.found !== want.found ||
            got.overflow !== want.overflow) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("result %0d expected: head %h/%h empty %b count %0d found %b/%h ovf %b",
                     result_index, want.head_id, want.head_time, want.queue_empty,
                     want.entry_count, want.found, want.found_id, want.overflow);
            $display("result %0d actual:   head %h/%h empty %b count %0d found %b/%h ovf %b",
                     result_index, got.head_id, got.head_time, got.queue_empty,
                     got.entry_count, got.found, got.found_id, got.overflow);
          end
          mismatch_count++;
        end
      end
      result_index++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_queue_full();
    test_random_traffic(410, 0, 0);
    test_random_traffic(410, 72, 0);
    test_random_traffic(410, 0, 72);
    test_random_traffic(410, 15, 15);
    test_backpressure();
    test_pause_until_drained();
    wait_results_done();
    repeat (QUEUE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
